/* design/cftp_pkg.sv */
// ----------------------------------------------------------------------------
// cftp_pkg
// shared widths, limits and reset values for the three point circle unit
// ----------------------------------------------------------------------------
`default_nettype none

package cftp_pkg;

    // configuration register
    localparam int TOL_W = 33;
    localparam logic [TOL_W-1:0] TOL_RESET = 33'd1;

    // result fields
    localparam int CENTRE_W = 32;
    localparam int RSQ_W    = 63;
    localparam int RAD_W    = 32;

    localparam logic signed [63:0] CENTRE_MAX = 64'sd2147483647;
    localparam logic signed [63:0] CENTRE_MIN = -64'sd2147483648;
    localparam logic [RSQ_W-1:0]   RSQ_MAX    = {RSQ_W{1'b1}};
    localparam logic [RAD_W-1:0]   RAD_MAX    = {RAD_W{1'b1}};

    // divider quotient kept below the overflow flag, and its clamp
    localparam int QUOT_W = 63;
    localparam logic [QUOT_W-1:0] QUOT_LIM = 63'h4000_0000_0000_0000;

    // square root: radicand below 2^65, root of 33 bits
    localparam int ROOT_W = 33;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

endpackage

`default_nettype wire

/* design/cftp_div_cell.sv */
// ----------------------------------------------------------------------------
// cftp_div_cell
// one restoring divide step for two lanes sharing a divisor, registered
// ----------------------------------------------------------------------------
`default_nettype none

module cftp_div_cell #(
    parameter int NUM_W  = 60,
    parameter int DIV_W  = 36,
    parameter int SIDE_W = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   vld_in,
    input  logic [DIV_W-1:0]                       div_in,
    input  logic [1:0][DIV_W-1:0]                  rem_in,
    input  logic [1:0][NUM_W-1:0]                  num_in,
    input  logic [1:0][cftp_pkg::QUOT_W-1:0]       quot_in,
    input  logic [1:0]                             ovf_in,
    input  logic [SIDE_W-1:0]                      side_in,
    output logic                                   vld_out,
    output logic [DIV_W-1:0]                       div_out,
    output logic [1:0][DIV_W-1:0]                  rem_out,
    output logic [1:0][NUM_W-1:0]                  num_out,
    output logic [1:0][cftp_pkg::QUOT_W-1:0]       quot_out,
    output logic [1:0]                             ovf_out,
    output logic [SIDE_W-1:0]                      side_out
);

    logic                              vld_reg;
    logic [DIV_W-1:0]                  div_reg;
    logic [1:0][DIV_W-1:0]             rem_reg;
    logic [1:0][DIV_W-1:0]             rem_next;
    logic [1:0][NUM_W-1:0]             num_reg;
    logic [1:0][NUM_W-1:0]             num_next;
    logic [1:0][cftp_pkg::QUOT_W-1:0]  quot_reg;
    logic [1:0][cftp_pkg::QUOT_W-1:0]  quot_next;
    logic [1:0]                        ovf_reg;
    logic [1:0]                        ovf_next;
    logic [SIDE_W-1:0]                 side_reg;

    always_comb
    begin
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        logic           take;
        for (int l = 0; l < 2; l++)
        begin
            trial = {rem_in[l], num_in[l][NUM_W-1]};
            diff  = trial - {1'b0, div_in};
            take  = (trial >= {1'b0, div_in});
            rem_next[l]  = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            num_next[l]  = {num_in[l][NUM_W-2:0], 1'b0};
            quot_next[l] = {quot_in[l][cftp_pkg::QUOT_W-2:0], take};
            ovf_next[l]  = ovf_in[l] | quot_in[l][cftp_pkg::QUOT_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg  <= div_in;
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            quot_reg <= quot_next;
            ovf_reg  <= ovf_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign div_out  = div_reg;
    assign rem_out  = rem_reg;
    assign num_out  = num_reg;
    assign quot_out = quot_reg;
    assign ovf_out  = ovf_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

/* design/cftp_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// cftp_sqrt_cell
// one digit-by-digit square root step, registered
// ----------------------------------------------------------------------------
`default_nettype none

module cftp_sqrt_cell #(
    parameter int SIDE_W = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           vld_in,
    input  logic [cftp_pkg::REM_W-1:0]     rem_in,
    input  logic [cftp_pkg::ROOT_W-1:0]    root_in,
    input  logic [cftp_pkg::SQ_W-1:0]      rad_in,
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           vld_out,
    output logic [cftp_pkg::REM_W-1:0]     rem_out,
    output logic [cftp_pkg::ROOT_W-1:0]    root_out,
    output logic [cftp_pkg::SQ_W-1:0]      rad_out,
    output logic [SIDE_W-1:0]              side_out
);

    logic                           vld_reg;
    logic [cftp_pkg::REM_W-1:0]     rem_reg;
    logic [cftp_pkg::REM_W-1:0]     rem_next;
    logic [cftp_pkg::ROOT_W-1:0]    root_reg;
    logic [cftp_pkg::ROOT_W-1:0]    root_next;
    logic [cftp_pkg::SQ_W-1:0]      rad_reg;
    logic [cftp_pkg::SQ_W-1:0]      rad_next;
    logic [SIDE_W-1:0]              side_reg;

    always_comb
    begin
        logic [cftp_pkg::REM_W+1:0] acc;
        logic [cftp_pkg::REM_W+1:0] trial;
        logic [cftp_pkg::REM_W+1:0] diff;
        logic                       take;
        acc   = {rem_in, rad_in[cftp_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, root_in, 2'b01};
        diff  = acc - trial;
        take  = (acc >= trial);
        rem_next  = take ? diff[cftp_pkg::REM_W-1:0] : acc[cftp_pkg::REM_W-1:0];
        root_next = {root_in[cftp_pkg::ROOT_W-2:0], take};
        rad_next  = {rad_in[cftp_pkg::SQ_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

/* design/circle_from_three_points_unit.sv */
// ----------------------------------------------------------------------------
// circle_from_three_points_unit
// circumcircle of three integer points: centre, squared radius and radius
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one word of three points a, b, c
//   output channel (out_valid/out_ready) carries one result word: valid_res,
//   centre_x/centre_y and radius with FRAC_BITS fraction bits, radius_squared
//   with 2*FRAC_BITS fraction bits, all rounded to nearest and saturated
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes collinear_tolerance;
//   cfg_ready is always high, write only while the unit is empty
//   points whose |det| is zero or below the tolerance give valid_res 0 and
//   all other fields zero
// timing
//   one word per cycle in and out while out_ready keeps the pipe moving; the
//   pipe holds the divider row (one quotient bit per cell,
//   3*COORD_BITS+FRAC_BITS+4 cells) and the square root row (33 cells)
//   reset empties the pipe and sets the tolerance to 1
//   when out_ready is low with a word waiting, the whole pipe holds and
//   in_ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module circle_from_three_points_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // point input
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_BITS-1:0]          point_a_x,
    input  logic signed [COORD_BITS-1:0]          point_a_y,
    input  logic signed [COORD_BITS-1:0]          point_b_x,
    input  logic signed [COORD_BITS-1:0]          point_b_y,
    input  logic signed [COORD_BITS-1:0]          point_c_x,
    input  logic signed [COORD_BITS-1:0]          point_c_y,
    // result output
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  valid_res,
    output logic signed [cftp_pkg::CENTRE_W-1:0]  centre_x,
    output logic signed [cftp_pkg::CENTRE_W-1:0]  centre_y,
    output logic [cftp_pkg::RSQ_W-1:0]            radius_squared,
    output logic [cftp_pkg::RAD_W-1:0]            radius,
    // tolerance write
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cftp_pkg::TOL_W-1:0]            cfg_data
);

    // widths of the exact integer datapath
    localparam int CW      = COORD_BITS;
    localparam int DIFF_W  = CW + 1;          // point differences
    localparam int SQS_W   = 2 * CW + 1;      // squared norms and their differences
    localparam int PD_W    = 2 * CW + 2;      // determinant products
    localparam int DET_W   = 2 * CW + 3;
    localparam int NUMP_W  = 3 * CW + 2;      // numerator products
    localparam int NUMS_W  = 3 * CW + 3;      // numerator sums
    localparam int MAG_W   = 3 * CW + 2;
    localparam int MDET_W  = 2 * CW + 2;
    localparam int CMP_W   = (MDET_W > cftp_pkg::TOL_W) ? MDET_W : cftp_pkg::TOL_W;
    localparam int NUM_W   = MAG_W + FRAC_BITS + 2;   // dividend, one cell per bit
    localparam int DIV_W   = MDET_W + 2;              // divisor is 4*|det|
    localparam int DSIDE_W = 3 + 2 * CW;
    localparam int SSIDE_W = 2 + 2 * cftp_pkg::CENTRE_W + cftp_pkg::RSQ_W;

    // valid bits of the front and back stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;
    logic out_valid_reg;

    // whole pipe moves unless a finished word is held at the output
    logic en;
    assign en        = out_ready || !out_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // tolerance register
    logic [cftp_pkg::TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= cftp_pkg::TOL_RESET;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic signed [CW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, cx1_reg, cy1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= point_a_x;
            ay1_reg <= point_a_y;
            bx1_reg <= point_b_x;
            by1_reg <= point_b_y;
            cx1_reg <= point_c_x;
            cy1_reg <= point_c_y;
        end
    end

    // ---------------- stage 2: differences and squared norms ----------------
    logic signed [DIFF_W-1:0] abx2_reg, aby2_reg, bcx2_reg, bcy2_reg;
    logic signed [SQS_W-1:0]  sa2_reg, sb2_reg, sc2_reg;
    logic signed [CW-1:0]     ax2_reg, ay2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abx2_reg <= DIFF_W'(ax1_reg) - DIFF_W'(bx1_reg);
            aby2_reg <= DIFF_W'(ay1_reg) - DIFF_W'(by1_reg);
            bcx2_reg <= DIFF_W'(bx1_reg) - DIFF_W'(cx1_reg);
            bcy2_reg <= DIFF_W'(by1_reg) - DIFF_W'(cy1_reg);
            sa2_reg  <= SQS_W'(ax1_reg) * SQS_W'(ax1_reg) + SQS_W'(ay1_reg) * SQS_W'(ay1_reg);
            sb2_reg  <= SQS_W'(bx1_reg) * SQS_W'(bx1_reg) + SQS_W'(by1_reg) * SQS_W'(by1_reg);
            sc2_reg  <= SQS_W'(cx1_reg) * SQS_W'(cx1_reg) + SQS_W'(cy1_reg) * SQS_W'(cy1_reg);
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
        end
    end

    // ---------------- stage 3: determinant products, norm differences ----------------
    logic signed [PD_W-1:0]   pd1_3_reg, pd2_3_reg;
    logic signed [SQS_W-1:0]  n1_3_reg, n2_3_reg;
    logic signed [DIFF_W-1:0] abx3_reg, aby3_reg, bcx3_reg, bcy3_reg;
    logic signed [CW-1:0]     ax3_reg, ay3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd1_3_reg <= PD_W'(abx2_reg) * PD_W'(bcy2_reg);
            pd2_3_reg <= PD_W'(bcx2_reg) * PD_W'(aby2_reg);
            n1_3_reg  <= sa2_reg - sb2_reg;
            n2_3_reg  <= sb2_reg - sc2_reg;
            abx3_reg  <= abx2_reg;
            aby3_reg  <= aby2_reg;
            bcx3_reg  <= bcx2_reg;
            bcy3_reg  <= bcy2_reg;
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
        end
    end

    // ---------------- stage 4: determinant, numerator products ----------------
    logic signed [DET_W-1:0]  det4_reg;
    logic signed [NUMP_W-1:0] px1_4_reg, px2_4_reg, py1_4_reg, py2_4_reg;
    logic signed [CW-1:0]     ax4_reg, ay4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det4_reg  <= DET_W'(pd1_3_reg) - DET_W'(pd2_3_reg);
            px1_4_reg <= NUMP_W'(n1_3_reg) * NUMP_W'(bcy3_reg);
            px2_4_reg <= NUMP_W'(n2_3_reg) * NUMP_W'(aby3_reg);
            py1_4_reg <= NUMP_W'(abx3_reg) * NUMP_W'(n2_3_reg);
            py2_4_reg <= NUMP_W'(bcx3_reg) * NUMP_W'(n1_3_reg);
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
        end
    end

    // ---------------- stage 5: numerators, |det| and collinear test ----------------
    logic signed [NUMS_W-1:0] numx5_reg, numy5_reg;
    logic [MDET_W-1:0]        mdet5_reg;
    logic                     dneg5_reg, coll5_reg;
    logic signed [CW-1:0]     ax5_reg, ay5_reg;
    logic signed [DET_W-1:0]  det_abs;
    logic [MDET_W-1:0]        mdet5_next;

    always_comb
    begin
        det_abs    = det4_reg[DET_W-1] ? -det4_reg : det4_reg;
        mdet5_next = det_abs[MDET_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx5_reg <= NUMS_W'(px1_4_reg) - NUMS_W'(px2_4_reg);
            numy5_reg <= NUMS_W'(py1_4_reg) - NUMS_W'(py2_4_reg);
            mdet5_reg <= mdet5_next;
            dneg5_reg <= det4_reg[DET_W-1];
            // a zero determinant is collinear even with a zero tolerance
            coll5_reg <= (det4_reg == '0) || (CMP_W'(mdet5_next) < CMP_W'(tol_reg));
            ax5_reg   <= ax4_reg;
            ay5_reg   <= ay4_reg;
        end
    end

    // ---------------- stage 6: rounded dividends and divisor ----------------
    // q = (|num|*2^(F+1) + 2|det|) / (4|det|) rounds |num|*2^F/(2|det|)
    logic [NUM_W-1:0]     nx6_reg, ny6_reg;
    logic [DIV_W-1:0]     d6_reg;
    logic                 sgnx6_reg, sgny6_reg, coll6_reg;
    logic signed [CW-1:0] ax6_reg, ay6_reg;
    logic signed [NUMS_W-1:0] numx_abs, numy_abs;

    always_comb
    begin
        numx_abs = numx5_reg[NUMS_W-1] ? -numx5_reg : numx5_reg;
        numy_abs = numy5_reg[NUMS_W-1] ? -numy5_reg : numy5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx6_reg   <= (NUM_W'(numx_abs[MAG_W-1:0]) << (FRAC_BITS + 1))
                         + NUM_W'({mdet5_reg, 1'b0});
            ny6_reg   <= (NUM_W'(numy_abs[MAG_W-1:0]) << (FRAC_BITS + 1))
                         + NUM_W'({mdet5_reg, 1'b0});
            d6_reg    <= {mdet5_reg, 2'b00};
            sgnx6_reg <= numx5_reg[NUMS_W-1] ^ dneg5_reg;
            sgny6_reg <= numy5_reg[NUMS_W-1] ^ dneg5_reg;
            coll6_reg <= coll5_reg;
            ax6_reg   <= ax5_reg;
            ay6_reg   <= ay5_reg;
        end
    end

    // ---------------- divider row: one quotient bit per cell ----------------
    logic                               dv_vld  [0:NUM_W];
    logic [DIV_W-1:0]                   dv_div  [0:NUM_W];
    logic [1:0][DIV_W-1:0]              dv_rem  [0:NUM_W];
    logic [1:0][NUM_W-1:0]              dv_num  [0:NUM_W];
    logic [1:0][cftp_pkg::QUOT_W-1:0]   dv_quot [0:NUM_W];
    logic [1:0]                         dv_ovf  [0:NUM_W];
    logic [DSIDE_W-1:0]                 dv_side [0:NUM_W];

    assign dv_vld[0]  = v6_reg;
    assign dv_div[0]  = d6_reg;
    assign dv_rem[0]  = '0;
    assign dv_num[0]  = {ny6_reg, nx6_reg};
    assign dv_quot[0] = '0;
    assign dv_ovf[0]  = '0;
    assign dv_side[0] = {coll6_reg, sgnx6_reg, sgny6_reg, ax6_reg, ay6_reg};

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_div
        cftp_div_cell #(
            .NUM_W  (NUM_W),
            .DIV_W  (DIV_W),
            .SIDE_W (DSIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (dv_vld[i]),
            .div_in   (dv_div[i]),
            .rem_in   (dv_rem[i]),
            .num_in   (dv_num[i]),
            .quot_in  (dv_quot[i]),
            .ovf_in   (dv_ovf[i]),
            .side_in  (dv_side[i]),
            .vld_out  (dv_vld[i+1]),
            .div_out  (dv_div[i+1]),
            .rem_out  (dv_rem[i+1]),
            .num_out  (dv_num[i+1]),
            .quot_out (dv_quot[i+1]),
            .ovf_out  (dv_ovf[i+1]),
            .side_out (dv_side[i+1])
        );
    end

    // ---------------- stage 7: clamp and sign the centre ----------------
    logic signed [63:0]   ox7_reg, oy7_reg;
    logic                 coll7_reg;
    logic signed [CW-1:0] ax7_reg, ay7_reg;
    logic                 d_coll, d_sgnx, d_sgny;
    logic signed [CW-1:0] d_ax, d_ay;
    logic [cftp_pkg::QUOT_W-1:0] qx_mag, qy_mag;
    logic signed [63:0]   qx_s, qy_s;

    always_comb
    begin
        {d_coll, d_sgnx, d_sgny, d_ax, d_ay} = dv_side[NUM_W];
        // far centre: clamp to 2^62 fixed units
        qx_mag = (dv_ovf[NUM_W][0] || dv_quot[NUM_W][0] > cftp_pkg::QUOT_LIM)
                 ? cftp_pkg::QUOT_LIM : dv_quot[NUM_W][0];
        qy_mag = (dv_ovf[NUM_W][1] || dv_quot[NUM_W][1] > cftp_pkg::QUOT_LIM)
                 ? cftp_pkg::QUOT_LIM : dv_quot[NUM_W][1];
        qx_s   = {1'b0, qx_mag};
        qy_s   = {1'b0, qy_mag};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox7_reg   <= d_sgnx ? -qx_s : qx_s;
            oy7_reg   <= d_sgny ? -qy_s : qy_s;
            coll7_reg <= d_coll;
            ax7_reg   <= d_ax;
            ay7_reg   <= d_ay;
        end
    end

    // ---------------- stage 8: offsets to point a, saturated centre ----------------
    logic signed [63:0]                   dx8_reg, dy8_reg;
    logic signed [cftp_pkg::CENTRE_W-1:0] cxs8_reg, cys8_reg;
    logic                                 coll8_reg;
    logic signed [63:0]                   ax_fix, ay_fix, ox_sat, oy_sat;

    always_comb
    begin
        ax_fix = 64'(ax7_reg) <<< FRAC_BITS;
        ay_fix = 64'(ay7_reg) <<< FRAC_BITS;
        ox_sat = (ox7_reg > cftp_pkg::CENTRE_MAX) ? cftp_pkg::CENTRE_MAX :
                 (ox7_reg < cftp_pkg::CENTRE_MIN) ? cftp_pkg::CENTRE_MIN : ox7_reg;
        oy_sat = (oy7_reg > cftp_pkg::CENTRE_MAX) ? cftp_pkg::CENTRE_MAX :
                 (oy7_reg < cftp_pkg::CENTRE_MIN) ? cftp_pkg::CENTRE_MIN : oy7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx8_reg   <= ax_fix - ox7_reg;
            dy8_reg   <= ay_fix - oy7_reg;
            cxs8_reg  <= ox_sat[cftp_pkg::CENTRE_W-1:0];
            cys8_reg  <= oy_sat[cftp_pkg::CENTRE_W-1:0];
            coll8_reg <= coll7_reg;
        end
    end

    // ---------------- stage 9: magnitudes, out-of-range flag ----------------
    // an offset of 2^32 or more puts r^2 past every output limit
    logic [31:0]                          mdx9_reg, mdy9_reg;
    logic                                 big9_reg, coll9_reg;
    logic signed [cftp_pkg::CENTRE_W-1:0] cxs9_reg, cys9_reg;
    logic signed [63:0]                   dx_abs, dy_abs;

    always_comb
    begin
        dx_abs = dx8_reg[63] ? -dx8_reg : dx8_reg;
        dy_abs = dy8_reg[63] ? -dy8_reg : dy8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mdx9_reg  <= dx_abs[31:0];
            mdy9_reg  <= dy_abs[31:0];
            big9_reg  <= (|dx_abs[63:32]) || (|dy_abs[63:32]);
            coll9_reg <= coll8_reg;
            cxs9_reg  <= cxs8_reg;
            cys9_reg  <= cys8_reg;
        end
    end

    // ---------------- stage 10: squares ----------------
    logic [63:0]                          sqx10_reg, sqy10_reg;
    logic                                 big10_reg, coll10_reg;
    logic signed [cftp_pkg::CENTRE_W-1:0] cxs10_reg, cys10_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx10_reg  <= 64'(mdx9_reg) * 64'(mdx9_reg);
            sqy10_reg  <= 64'(mdy9_reg) * 64'(mdy9_reg);
            big10_reg  <= big9_reg;
            coll10_reg <= coll9_reg;
            cxs10_reg  <= cxs9_reg;
            cys10_reg  <= cys9_reg;
        end
    end

    // ---------------- stage 11: squared radius ----------------
    logic [cftp_pkg::SQ_W-1:0]            rad11_reg;
    logic [cftp_pkg::RSQ_W-1:0]           r2s11_reg;
    logic                                 big11_reg, coll11_reg;
    logic signed [cftp_pkg::CENTRE_W-1:0] cxs11_reg, cys11_reg;
    logic [64:0]                          r2_sum;

    assign r2_sum = 65'(sqx10_reg) + 65'(sqy10_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad11_reg  <= cftp_pkg::SQ_W'(r2_sum);
            r2s11_reg  <= (big10_reg || (|r2_sum[64:63])) ? cftp_pkg::RSQ_MAX
                                                           : r2_sum[62:0];
            big11_reg  <= big10_reg;
            coll11_reg <= coll10_reg;
            cxs11_reg  <= cxs10_reg;
            cys11_reg  <= cys10_reg;
        end
    end

    // ---------------- square root row: one root bit per cell ----------------
    logic                          sq_vld  [0:cftp_pkg::ROOT_W];
    logic [cftp_pkg::REM_W-1:0]    sq_rem  [0:cftp_pkg::ROOT_W];
    logic [cftp_pkg::ROOT_W-1:0]   sq_root [0:cftp_pkg::ROOT_W];
    logic [cftp_pkg::SQ_W-1:0]     sq_rad  [0:cftp_pkg::ROOT_W];
    logic [SSIDE_W-1:0]            sq_side [0:cftp_pkg::ROOT_W];

    assign sq_vld[0]  = v11_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = rad11_reg;
    assign sq_side[0] = {coll11_reg, big11_reg, cxs11_reg, cys11_reg, r2s11_reg};

    for (genvar k = 0; k < cftp_pkg::ROOT_W; k++)
    begin : g_sqrt
        cftp_sqrt_cell #(
            .SIDE_W (SSIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (sq_vld[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .rad_in   (sq_rad[k]),
            .side_in  (sq_side[k]),
            .vld_out  (sq_vld[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1]),
            .rad_out  (sq_rad[k+1]),
            .side_out (sq_side[k+1])
        );
    end

    // ---------------- output stage: round, saturate, mask collinear ----------------
    logic                                 s_coll, s_big;
    logic signed [cftp_pkg::CENTRE_W-1:0] s_cx, s_cy;
    logic [cftp_pkg::RSQ_W-1:0]           s_r2;
    logic [cftp_pkg::ROOT_W:0]            root_rnd;
    logic [cftp_pkg::RAD_W-1:0]           rad_sat;

    logic                                 valid_res_reg;
    logic signed [cftp_pkg::CENTRE_W-1:0] centre_x_reg, centre_y_reg;
    logic [cftp_pkg::RSQ_W-1:0]           radius_squared_reg;
    logic [cftp_pkg::RAD_W-1:0]           radius_reg;

    always_comb
    begin
        {s_coll, s_big, s_cx, s_cy, s_r2} = sq_side[cftp_pkg::ROOT_W];
        // round to nearest: step up when the remainder exceeds the root
        root_rnd = (cftp_pkg::ROOT_W + 1)'(sq_root[cftp_pkg::ROOT_W])
                   + (cftp_pkg::ROOT_W + 1)'(sq_rem[cftp_pkg::ROOT_W]
                      > cftp_pkg::REM_W'(sq_root[cftp_pkg::ROOT_W]));
        rad_sat  = (s_big || (|root_rnd[cftp_pkg::ROOT_W:cftp_pkg::RAD_W]))
                   ? cftp_pkg::RAD_MAX : root_rnd[cftp_pkg::RAD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valid_res_reg      <= !s_coll;
            centre_x_reg       <= s_coll ? '0 : s_cx;
            centre_y_reg       <= s_coll ? '0 : s_cy;
            radius_squared_reg <= s_coll ? '0 : s_r2;
            radius_reg         <= s_coll ? '0 : rad_sat;
        end
    end

    // ---------------- valid bits of the unit's own stages ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= dv_vld[NUM_W];
            v8_reg        <= v7_reg;
            v9_reg        <= v8_reg;
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            out_valid_reg <= sq_vld[cftp_pkg::ROOT_W];
        end
    end

    assign out_valid      = out_valid_reg;
    assign valid_res      = valid_res_reg;
    assign centre_x       = centre_x_reg;
    assign centre_y       = centre_y_reg;
    assign radius_squared = radius_squared_reg;
    assign radius         = radius_reg;

endmodule

`default_nettype wire

/* test/circle_from_three_points_unit_checker.sv */
// ----------------------------------------------------------------------------
// circle_from_three_points_unit_checker
// watches the point, result and tolerance channels, predicts every result
// word from the accepted points and compares it with what the unit returns
// ----------------------------------------------------------------------------
module circle_from_three_points_unit_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [15:0]                   point_a_x,
    input  logic signed [15:0]                   point_a_y,
    input  logic signed [15:0]                   point_b_x,
    input  logic signed [15:0]                   point_b_y,
    input  logic signed [15:0]                   point_c_x,
    input  logic signed [15:0]                   point_c_y,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 valid_res,
    input  logic signed [cftp_pkg::CENTRE_W-1:0] centre_x,
    input  logic signed [cftp_pkg::CENTRE_W-1:0] centre_y,
    input  logic [cftp_pkg::RSQ_W-1:0]           radius_squared,
    input  logic [cftp_pkg::RAD_W-1:0]           radius,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [cftp_pkg::TOL_W-1:0]           cfg_data,
    output int                                   fail_count,
    output int                                   circles_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;

    typedef struct {
        logic                                 found;
        logic signed [cftp_pkg::CENTRE_W-1:0] cx;
        logic signed [cftp_pkg::CENTRE_W-1:0] cy;
        logic [cftp_pkg::RSQ_W-1:0]           rsq;
        logic [cftp_pkg::RAD_W-1:0]           rad;
    } circle_t;

    circle_t                    circle_queue[$];
    logic [cftp_pkg::TOL_W-1:0] tolerance;

    assign circles_pending = circle_queue.size();

    function automatic longint centre_axis(logic signed [127:0] num, longint den);
        logic [127:0] mag;
        logic [127:0] quot;
        logic [127:0] mden;
        logic         neg;
        neg  = num[127];
        mag  = neg ? -num : num;
        mden = (den < 0) ? -den : den;
        mag  = mag << (FRAC + 1);
        quot = (mag + mden) / (mden << 1);
        if (quot > (128'd1 << 62))
            quot = 128'd1 << 62;
        return (neg != (den < 0)) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp_centre(longint v);
        if (v > cftp_pkg::CENTRE_MAX)
            return 32'sh7fff_ffff;
        if (v < cftp_pkg::CENTRE_MIN)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic circle_t circumcircle(longint ax, longint ay, longint bx,
                                             longint by, longint cx, longint cy);
        circle_t             c;
        longint              abx, aby, bcx, bcy, det, blen, n1, n2, ox, oy, dx, dy;
        logic [63:0]         mdet, mdx, mdy, root;
        logic signed [127:0] s1, s2, s3, s4;
        logic [127:0]        r2, t, rem;
        abx = ax - bx;
        aby = ay - by;
        bcx = bx - cx;
        bcy = by - cy;
        det = abx * bcy - bcx * aby;
        mdet = (det < 0) ? -det : det;
        c = '{1'b0, '0, '0, '0, '0};
        if (det == 0 || mdet < tolerance)
            return c;
        blen = bx * bx + by * by;
        n1 = ax * ax + ay * ay - blen;
        n2 = blen - (cx * cx + cy * cy);
        s1 = n1;
        s2 = bcy;
        s3 = n2;
        s4 = aby;
        ox = centre_axis(s1 * s2 - s3 * s4, det * 2);
        s1 = abx;
        s4 = bcx;
        oy = centre_axis(s1 * s3 - s4 * n1, det * 2);
        dx = ax * (64'sd1 << FRAC) - ox;
        dy = ay * (64'sd1 << FRAC) - oy;
        mdx = (dx < 0) ? -dx : dx;
        mdy = (dy < 0) ? -dy : dy;
        r2 = 128'(mdx) * 128'(mdx) + 128'(mdy) * 128'(mdy);
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = 128'(root | (64'd1 << b));
            if (t * t <= r2)
                root = t[63:0];
        end
        rem = r2 - 128'(root) * 128'(root);
        if (rem > 128'(root))
            root = root + 1;
        c.found = 1'b1;
        c.cx    = clamp_centre(ox);
        c.cy    = clamp_centre(oy);
        c.rsq   = (r2 > 128'(cftp_pkg::RSQ_MAX)) ? cftp_pkg::RSQ_MAX : r2[62:0];
        c.rad   = (root > 64'(cftp_pkg::RAD_MAX)) ? cftp_pkg::RAD_MAX : root[31:0];
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        circle_t want;
        if (!rst_n)
        begin
            tolerance  <= cftp_pkg::TOL_RESET;
            fail_count <= 0;
            circle_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tolerance <= cfg_data;
            if (in_valid && in_ready)
                circle_queue.push_back(circumcircle(point_a_x, point_a_y, point_b_x,
                                                    point_b_y, point_c_x, point_c_y));
            if (out_valid && out_ready)
            begin
                if (circle_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word: valid_res %0d", valid_res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = circle_queue.pop_front();
                    if (want.found !== valid_res || want.cx !== centre_x
                        || want.cy !== centre_y || want.rsq !== radius_squared
                        || want.rad !== radius)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                     want.found, want.cx, want.cy, want.rsq, want.rad,
                                     valid_res, centre_x, centre_y, radius_squared, radius);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/circle_from_three_points_unit_tb.sv */
// ----------------------------------------------------------------------------
// circle_from_three_points_unit_tb
// drives point triples and tolerance writes into the circle unit under
// random idling on both sides; the checker predicts and compares each word
// ----------------------------------------------------------------------------
module circle_from_three_points_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // pipe latency at default parameters
    localparam int LATENCY     = 105;
    localparam int CYCLE_LIMIT = 400000;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic signed [15:0]                   point_a_x;
    logic signed [15:0]                   point_a_y;
    logic signed [15:0]                   point_b_x;
    logic signed [15:0]                   point_b_y;
    logic signed [15:0]                   point_c_x;
    logic signed [15:0]                   point_c_y;
    logic                                 out_valid;
    logic                                 out_ready;
    logic                                 valid_res;
    logic signed [cftp_pkg::CENTRE_W-1:0] centre_x;
    logic signed [cftp_pkg::CENTRE_W-1:0] centre_y;
    logic [cftp_pkg::RSQ_W-1:0]           radius_squared;
    logic [cftp_pkg::RAD_W-1:0]           radius;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [cftp_pkg::TOL_W-1:0]           cfg_data;
    int                                   fail_count;
    int                                   circles_pending;
    int                                   cycle_count;
    // when set, neither side idles
    logic                                 busy_phase;

    circle_from_three_points_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_a_x(point_a_x), .point_a_y(point_a_y),
        .point_b_x(point_b_x), .point_b_y(point_b_y),
        .point_c_x(point_c_x), .point_c_y(point_c_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .valid_res(valid_res), .centre_x(centre_x), .centre_y(centre_y),
        .radius_squared(radius_squared), .radius(radius),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    circle_from_three_points_unit_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_a_x(point_a_x), .point_a_y(point_a_y),
        .point_b_x(point_b_x), .point_b_y(point_b_y),
        .point_c_x(point_c_x), .point_c_y(point_c_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .valid_res(valid_res), .centre_x(centre_x), .centre_y(centre_y),
        .radius_squared(radius_squared), .radius(radius),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .circles_pending(circles_pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // watchdog on total cycles
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("circle_from_three_points_unit_tb failed");
            $finish;
        end
    end

    // result side: per word a random stall before taking it
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            stall = busy_phase ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            while (!out_valid)
                @(posedge clk);
        end
    end

    // one point word, called at a rising edge; valid stays up across back to back words
    task automatic send_points(input int ax, input int ay, input int bx,
                               input int by, input int cx, input int cy);
        int gap;
        gap = busy_phase ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_a_x <= 16'(ax);
        point_a_y <= 16'(ay);
        point_b_x <= 16'(bx);
        point_b_y <= 16'(by);
        point_c_x <= 16'(cx);
        point_c_y <= 16'(cy);
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // let every result drain, then write the tolerance while the unit is empty
    task automatic set_tolerance(input logic [cftp_pkg::TOL_W-1:0] tol);
        in_valid <= 1'b0;
        // the checker queues the last word at this same edge
        @(posedge clk);
        while (circles_pending != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_data  <= tol;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_points(input int count);
        int ax, ay, bx, by, cx, cy;
        int k, mode, span;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            ax = int'($urandom);
            ay = int'($urandom);
            bx = int'($urandom);
            by = int'($urandom);
            cx = int'($urandom);
            cy = int'($urandom);
            if (mode < 3)
            begin
                // small triangles near one spot
                span = $urandom_range(1, 64);
                bx = ax + int'($urandom_range(0, 2 * span)) - span;
                by = ay + int'($urandom_range(0, 2 * span)) - span;
                cx = ax + int'($urandom_range(0, 2 * span)) - span;
                cy = ay + int'($urandom_range(0, 2 * span)) - span;
            end
            else if (mode < 6)
            begin
                // near collinear: c on the line a..b, nudged a little
                ax = int'($urandom_range(0, 4000)) - 2000;
                ay = int'($urandom_range(0, 4000)) - 2000;
                bx = int'($urandom_range(0, 4000)) - 2000;
                by = int'($urandom_range(0, 4000)) - 2000;
                k  = int'($urandom_range(0, 6)) - 3;
                cx = ax + k * (bx - ax) + int'($urandom_range(0, 4)) - 2;
                cy = ay + k * (by - ay) + int'($urandom_range(0, 4)) - 2;
            end
            else if (mode == 6)
            begin
                // repeated points
                cx = ax;
                cy = ay;
            end
            send_points(ax, ay, bx, by, cx, cy);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        point_a_x   <= '0;
        point_a_y   <= '0;
        point_b_x   <= '0;
        point_b_y   <= '0;
        point_c_x   <= '0;
        point_c_y   <= '0;
        busy_phase  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset tolerance: plain triangles, extremes, degenerate cases
        send_points(0, 0, 4, 0, 0, 3);
        send_points(-32768, -32768, 32767, -32768, -32768, 32767);
        send_points(32767, 32767, -32768, 32767, 32767, -32768);
        send_points(0, 0, 0, 0, 0, 0);                         // all equal
        send_points(1, 1, 2, 2, 3, 3);                         // collinear, det zero
        send_points(-32768, -32768, 32767, 32767, 32767, 32766); // far centre
        send_points(-32768, 0, 32767, 0, 0, 1);                // far centre, other axis
        send_points(0, 0, 1, 0, 0, 1);                         // det magnitude one
        send_points(-1, -1, 1, -1, 0, 1);
        send_points(32767, 0, 0, 32767, -32768, 0);
        send_points(-32768, -32768, -32767, -32768, -32768, -32767);
        send_points(100, -200, -300, 400, 500, 600);

        // tolerance zero: zero determinant must still count as collinear
        set_tolerance('0);
        send_points(5, 5, 5, 5, 7, 9);
        send_points(-3, 0, 0, 0, 3, 0);
        send_points(0, 0, 1, 0, 0, 1);

        // largest tolerance: everything collinear
        set_tolerance({cftp_pkg::TOL_W{1'b1}});
        send_points(-32768, -32768, 32767, -32768, -32768, 32767);
        send_points(0, 0, 4, 0, 0, 3);

        // tolerance on the edge of a known determinant (12)
        set_tolerance(33'd12);
        send_points(0, 0, 4, 0, 0, 3);
        set_tolerance(33'd13);
        send_points(0, 0, 4, 0, 0, 3);

        // random phases with several tolerances; one phase with no idling
        set_tolerance(cftp_pkg::TOL_RESET);
        random_points(500);
        set_tolerance(33'd1000);
        busy_phase <= 1'b1;
        random_points(200);
        busy_phase <= 1'b0;
        set_tolerance('0);
        random_points(300);
        set_tolerance(33'h1_0000_0000);
        random_points(100);
        set_tolerance(33'd40);
        random_points(430);
        in_valid <= 1'b0;

        while (circles_pending != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("circle_from_three_points_unit_tb passed");
        else
            $display("circle_from_three_points_unit_tb failed");
        $finish;
    end

endmodule
